### rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  // session limits
  localparam int MAX_FRAME_COUNT = 128;
  localparam int MAX_WINDOW      = 64;

  // field widths
  localparam int FRAME_W = 7;   // frame number
  localparam int BASE_W  = 8;   // window base, 0..frame_total
  localparam int TOTAL_W = 8;   // frame_total register
  localparam int WIN_W   = 7;   // window_length register
  localparam int CFG_W   = 8;   // widest register
  localparam int CMD_W   = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SEND_ROUND = 2'd0,
    CMD_ACK        = 2'd1,
    CMD_RESTART    = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  // register indexes
  typedef enum logic {
    REG_FRAME_TOTAL   = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } reg_idx_t;

  // result kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

endpackage

`default_nettype wire

### rtl/srsw_if.sv
// ----------------------------------------------------------------------------
// srsw channel interfaces
// Command request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srsw_in_if;
  import srsw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FRAME_W-1:0] frame_id;

  modport source (output valid, command, frame_id, input ready);
  modport sink   (input valid, command, frame_id, output ready);
endinterface

interface srsw_out_if;
  import srsw_pkg::*;

  logic               valid;
  logic               ready;
  logic               item_kind;
  logic [FRAME_W-1:0] send_frame;
  logic [BASE_W-1:0]  window_base;
  logic               all_done;
  logic               ack_rejected;
  logic               config_invalid;
  logic               last_item;

  modport source (output valid, item_kind, send_frame, window_base, all_done,
                  ack_rejected, config_invalid, last_item, input ready);
  modport sink   (input valid, item_kind, send_frame, window_base, all_done,
                  ack_rejected, config_invalid, last_item, output ready);
endinterface

`default_nettype wire

### rtl/selective_repeat_sender_window.sv
// Flow: a restart first clears all 128 bitmap entries and an ack slides the base, then
// a status is loaded; a send round loads its frames as it probes the window entries.
// Throughput: one request at a time, the next taken once the last result is loaded; one
// bitmap entry probed per cycle unless a frame waits on a stalled output (up to 64 per
// round, 128 per slide).
// Reset: synchronous active-low; bitmap clearing pass, base 0, frame_total 128, window 4.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Selective-repeat sender: window base, acknowledge bitmap, send rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire [srsw_pkg::CFG_W-1:0]   cfg_data,
  srsw_in_if.sink                     in_ch,
  srsw_out_if.source                  out_ch
);
  import srsw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FLUSH,
    ST_SLIDE,
    ST_REPORT
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [FRAME_W-1:0] fid_r, fid_nxt;
  logic [BASE_W-1:0]  end_r, end_nxt;
  logic [BASE_W-1:0]  idx_r, idx_nxt;
  logic [FRAME_W-1:0] pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic               rej_r, rej_nxt;
  logic               inval_r, inval_nxt;
  logic [TOTAL_W-1:0] frame_total_r;
  logic [WIN_W-1:0]   window_length_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic [BASE_W-1:0]  out_base_r, out_base_nxt;
  logic               out_done_r, out_done_nxt;
  logic               out_rej_r, out_rej_nxt;
  logic               out_inval_r, out_inval_nxt;
  logic               out_last_r, out_last_nxt;

  logic               map_we;
  logic [FRAME_W-1:0] map_waddr;
  logic               map_wbit;
  logic [FRAME_W-1:0] map_raddr;
  logic               map_rbit;
  logic               probe_bit;
  logic [BASE_W-1:0]  ptr_sel;
  logic [BASE_W-1:0]  ptr_bound;
  logic [BASE_W-1:0]  ptr_inc;
  logic               ptr_lt;
  logic [BASE_W:0]    win_sum;
  logic               cfg_ok;
  logic               base_done;
  logic               out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r   <= TOTAL_W'(MAX_FRAME_COUNT);
      window_length_r <= WIN_W'(4);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_TOTAL:   frame_total_r   <= cfg_data;
        REG_WINDOW_LENGTH: window_length_r <= cfg_data[WIN_W-1:0];
      endcase
    end
  end

  // register sanity
  assign cfg_ok = (frame_total_r != '0)
               && (frame_total_r <= TOTAL_W'(MAX_FRAME_COUNT))
               && (window_length_r != '0)
               && (window_length_r <= WIN_W'(MAX_WINDOW))
               && ({1'b0, window_length_r} <= frame_total_r);

  assign base_done = (base_r >= frame_total_r);
  assign win_sum   = {1'b0, base_r} + {2'b00, window_length_r};
  assign out_free  = !out_valid_r || out_ch.ready;

  // shared pointer unit: step for clear, compare and step for scan and slide
  assign ptr_sel   = (state_r == ST_SLIDE) ? base_r : idx_r;
  assign ptr_bound = (state_r == ST_SLIDE) ? frame_total_r : end_r;
  assign ptr_lt    = (ptr_sel < ptr_bound);
  assign ptr_inc   = ptr_sel + BASE_W'(1);

  // read address runs one step ahead so the data lines up with the pointer
  assign map_raddr = (state_nxt == ST_SLIDE) ? base_nxt[FRAME_W-1:0]
                                             : idx_nxt[FRAME_W-1:0];

  // the frame just acknowledged may still read back as clear on the first slide probe
  assign probe_bit = map_rbit
                  || ((state_r == ST_SLIDE) && (base_r[FRAME_W-1:0] == fid_r));

  srsw_map #(
    .DATA_W (1),
    .DEPTH  (MAX_FRAME_COUNT)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wbit),
    .rd_addr (map_raddr),
    .rd_data (map_rbit)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    fid_nxt       = fid_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    base_nxt      = base_r;
    rej_nxt       = rej_r;
    inval_nxt     = inval_r;
    map_we        = 1'b0;
    map_waddr     = fid_r;
    map_wbit      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_frame_nxt = out_frame_r;
    out_base_nxt  = out_base_r;
    out_done_nxt  = out_done_r;
    out_rej_nxt   = out_rej_r;
    out_inval_nxt = out_inval_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      // clearing pass over the bitmap, after reset and on restart
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = idx_r[FRAME_W-1:0];
        map_wbit  = 1'b0;
        idx_nxt   = ptr_inc;
        if (idx_r[FRAME_W-1:0] == '1) begin
          state_nxt = (cmd_r == CMD_RESTART) ? ST_REPORT : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.command);
          fid_nxt   = in_ch.frame_id;
          // window end = min(base + window, total)
          end_nxt   = (win_sum < {1'b0, frame_total_r}) ? win_sum[BASE_W-1:0]
                                                        : frame_total_r;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        rej_nxt   = 1'b0;
        inval_nxt = 1'b0;
        if (!cfg_ok) begin
          inval_nxt = 1'b1;
          state_nxt = ST_REPORT;
        end else begin
          unique case (cmd_r)
            CMD_SEND_ROUND: begin
              if (base_done) begin
                state_nxt = ST_REPORT;
              end else begin
                idx_nxt    = base_r;
                pend_v_nxt = 1'b0;
                state_nxt  = ST_SCAN;
              end
            end
            CMD_ACK: begin
              if (base_done || ({1'b0, fid_r} < base_r) || ({1'b0, fid_r} >= end_r)) begin
                rej_nxt   = 1'b1;
                state_nxt = ST_REPORT;
              end else begin
                map_we    = 1'b1;
                map_waddr = fid_r;
                map_wbit  = 1'b1;
                state_nxt = ST_SLIDE;
              end
            end
            CMD_RESTART: begin
              base_nxt  = '0;
              idx_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            CMD_UNUSED: begin
              state_nxt = ST_REPORT;
            end
          endcase
        end
      end

      // walk the window, holding one frame back to mark the last
      ST_SCAN: begin
        if (!ptr_lt) begin
          state_nxt = pend_v_r ? ST_FLUSH : ST_REPORT;
        end else if (probe_bit) begin
          idx_nxt = ptr_inc;
        end else if (!pend_v_r) begin
          pend_nxt   = idx_r[FRAME_W-1:0];
          pend_v_nxt = 1'b1;
          idx_nxt    = ptr_inc;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FRAME;
          out_frame_nxt = pend_r;
          out_base_nxt  = base_r;
          out_done_nxt  = 1'b0;
          out_rej_nxt   = 1'b0;
          out_inval_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          pend_nxt      = idx_r[FRAME_W-1:0];
          idx_nxt       = ptr_inc;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FRAME;
          out_frame_nxt = pend_r;
          out_base_nxt  = base_r;
          out_done_nxt  = 1'b0;
          out_rej_nxt   = 1'b0;
          out_inval_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // slide the base over acknowledged frames
      ST_SLIDE: begin
        if (ptr_lt && probe_bit) begin
          base_nxt = ptr_inc;
        end else begin
          state_nxt = ST_REPORT;
        end
      end

      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_STATUS;
          out_frame_nxt = '0;
          out_base_nxt  = base_r;
          out_done_nxt  = !inval_r && base_done;
          out_rej_nxt   = rej_r;
          out_inval_nxt = inval_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cmd_r       <= CMD_SEND_ROUND;
      idx_r       <= '0;
      base_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      idx_r       <= idx_nxt;
      base_r      <= base_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fid_r       <= fid_nxt;
    end_r       <= end_nxt;
    pend_r      <= pend_nxt;
    rej_r       <= rej_nxt;
    inval_r     <= inval_nxt;
    out_kind_r  <= out_kind_nxt;
    out_frame_r <= out_frame_nxt;
    out_base_r  <= out_base_nxt;
    out_done_r  <= out_done_nxt;
    out_rej_r   <= out_rej_nxt;
    out_inval_r <= out_inval_nxt;
    out_last_r  <= out_last_nxt;
  end

  // channel ports
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.item_kind      = out_kind_r;
  assign out_ch.send_frame     = out_frame_r;
  assign out_ch.window_base    = out_base_r;
  assign out_ch.all_done       = out_done_r;
  assign out_ch.ack_rejected   = out_rej_r;
  assign out_ch.config_invalid = out_inval_r;
  assign out_ch.last_item      = out_last_r;

endmodule

`default_nettype wire

### rtl/srsw_map.sv
// ----------------------------------------------------------------------------
// srsw_map
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_map #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 128
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire [DATA_W-1:0]         wr_data,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write, and read of the old contents on the same edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/srsw_checker.sv
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks of the sender window, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire                         out_item_kind,
  input wire [srsw_pkg::FRAME_W-1:0] out_send_frame,
  input wire [srsw_pkg::BASE_W-1:0]  out_window_base,
  input wire                         out_all_done,
  input wire                         out_ack_rejected,
  input wire                         out_config_invalid,
  input wire                         out_last_item
);
  import srsw_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_frame)
      && $stable(out_item_kind) && $stable(out_last_item))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a status report always closes its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_STATUS |-> out_last_item)
    else $error("status report not marked last");

  // frames to send carry no flags and lie at or above the base
  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_FRAME |-> !out_all_done && !out_ack_rejected
      && !out_config_invalid && ({1'b0, out_send_frame} >= out_window_base))
    else $error("frame result inconsistent");

  // invalid registers report nothing else
  a_inval_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_config_invalid |-> !out_all_done && !out_ack_rejected)
    else $error("invalid config report carries other flags");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_item_kind      (out_ch.item_kind),
  .out_send_frame     (out_ch.send_frame),
  .out_window_base    (out_ch.window_base),
  .out_all_done       (out_ch.all_done),
  .out_ack_rejected   (out_ch.ack_rejected),
  .out_config_invalid (out_ch.config_invalid),
  .out_last_item      (out_ch.last_item)
);

`default_nettype wire
